>>> design/crc32_parity_frame_checker_core_defines.svh
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC32_PARITY_FRAME_CHECKER_CORE_DEFINES_SVH
`define CRC32_PARITY_FRAME_CHECKER_CORE_DEFINES_SVH

// condition holds at every edge
`define CRCPF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent at the next edge
`define CRCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/crcpf_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - package
// Beat types, register codes and the single-bit CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcpf_pkg;

    localparam int unsigned CHECK_WIDTH = 32;
    localparam logic [CHECK_WIDTH-1:0] POLY_LOW = 32'h04C1_1DB7;
    localparam logic [3:0] MAX_BITS = 4'd8;

    localparam logic [1:0] MODE_EVEN    = 2'd0;
    localparam logic [1:0] MODE_ODD     = 2'd1;
    localparam logic [1:0] MODE_CRC     = 2'd2;
    localparam logic [1:0] MODE_CRC_ALT = 2'd3;

    localparam logic DIR_GENERATE = 1'b0;
    localparam logic DIR_VERIFY   = 1'b1;

    localparam logic REG_CHECK_MODE = 1'b0;
    localparam logic REG_DIRECTION  = 1'b1;

    typedef struct packed {
        logic [7:0] data_bits;
        logic [3:0] bit_count;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [CHECK_WIDTH-1:0] check_value;
        logic                   error;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] check_mode;
        logic       direction;
    } cfg_t;

    function automatic logic [CHECK_WIDTH-1:0] crc_bit(
        input logic [CHECK_WIDTH-1:0] rem,
        input logic                   b,
        input logic                   dir
    );
        logic                   top;
        logic [CHECK_WIDTH-1:0] sh;
        top = rem[CHECK_WIDTH-1];
        if (dir == DIR_GENERATE)
        begin
            sh = {rem[CHECK_WIDTH-2:0], 1'b0};
            if (top ^ b)
            begin
                sh = sh ^ POLY_LOW;
            end
        end
        else
        begin
            sh = {rem[CHECK_WIDTH-2:0], b};
            if (top)
            begin
                sh = sh ^ POLY_LOW;
            end
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

>>> design/crcpf_in_stage.sv
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - input register
// Holds one beat; a final beat waits here while the result slot is full.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_in_stage (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  crcpf_pkg::in_beat_t in_data,
    input  wire                 out_free,
    output logic                advance,
    output crcpf_pkg::in_beat_t item
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    crcpf_pkg::in_beat_t s1_item_reg;

    assign advance       = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign in_ready      = !s1_valid_reg || advance;
    assign s1_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign item          = s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> design/crcpf_engine.sv
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - accumulator engine
// Eight-bit unrolled CRC and parity update; builds the frame result.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_engine (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  advance,
    input  crcpf_pkg::in_beat_t  item,
    input  crcpf_pkg::cfg_t      cfg,
    output crcpf_pkg::out_beat_t result
);

    logic [crcpf_pkg::CHECK_WIDTH-1:0] rem_reg;
    logic [crcpf_pkg::CHECK_WIDTH-1:0] rem_next;
    logic                              par_reg;
    logic                              par_next;
    logic [3:0]                        nbits;
    logic                              p;
    logic                              is_crc;

    assign nbits  = (item.bit_count > crcpf_pkg::MAX_BITS) ? crcpf_pkg::MAX_BITS
                                                           : item.bit_count;
    assign is_crc = cfg.check_mode inside {crcpf_pkg::MODE_CRC, crcpf_pkg::MODE_CRC_ALT};

    always_comb
    begin
        rem_next = rem_reg;
        par_next = par_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < nbits)
            begin
                rem_next = crcpf_pkg::crc_bit(rem_next, item.data_bits[7-i], cfg.direction);
                par_next = par_next ^ item.data_bits[7-i];
            end
        end
    end

    assign p = par_next ^ (cfg.check_mode == crcpf_pkg::MODE_ODD);

    always_comb
    begin
        if (is_crc)
        begin
            result.check_value = rem_next;
            result.error       = (cfg.direction == crcpf_pkg::DIR_VERIFY) && (rem_next != '0);
        end
        else
        begin
            result.check_value = {{(crcpf_pkg::CHECK_WIDTH-1){1'b0}}, p};
            result.error       = (cfg.direction == crcpf_pkg::DIR_VERIFY) && p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            par_reg <= 1'b0;
        end
        else if (advance)
        begin
            rem_reg <= item.last ? '0 : rem_next;
            par_reg <= item.last ? 1'b0 : par_next;
        end
    end

endmodule

`default_nettype wire

>>> design/crcpf_out_stage.sv
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - result register
// One-entry output slot for the end-of-frame result.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_out_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  load,
    input  crcpf_pkg::out_beat_t result,
    output logic                 out_free,
    output logic                 out_valid,
    input  wire                  out_ready,
    output crcpf_pkg::out_beat_t out_data
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    crcpf_pkg::out_beat_t out_data_reg;

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> design/crc32_parity_frame_checker_core.sv
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - top level
// Streams frame beats of up to eight bits, emits parity or CRC-32 per frame.
// ----------------------------------------------------------------------------
// One beat is taken every cycle unless a final beat is held in the input register;
// a frame result is offered from the result register in the cycle after its
// final beat leaves the input register. The path holds two registers, the
// input register and the result register; the eight-step unrolled CRC update
// sits between them. A final beat holds in the input register only while an
// earlier result is still waiting to be taken.
`default_nettype none

`include "crc32_parity_frame_checker_core_defines.svh"

module crc32_parity_frame_checker_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  crcpf_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output crcpf_pkg::out_beat_t out_data,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire [1:0]            cfg_wdata
);

    crcpf_pkg::cfg_t      cfg_reg;
    crcpf_pkg::in_beat_t  item;
    crcpf_pkg::out_beat_t result;
    logic                 advance;
    logic                 out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_mode <= crcpf_pkg::MODE_EVEN;
            cfg_reg.direction  <= crcpf_pkg::DIR_GENERATE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crcpf_pkg::REG_CHECK_MODE: cfg_reg.check_mode <= cfg_wdata;
                crcpf_pkg::REG_DIRECTION:  cfg_reg.direction  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    crcpf_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    crcpf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    crcpf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && item.last),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `CRCPF_ASSERT(a_stall_only_on_final,
                  !(!in_ready && !(item.last && out_valid && !out_ready)),
                  "input stalled without a pending result")
    `CRCPF_ASSERT(a_ready_when_slot_empty, out_valid || in_ready,
                  "input not ready with empty result slot")
    `CRCPF_ASSERT_NEXT(a_result_follows_final, advance && item.last, out_valid,
                       "final beat gave no result")

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// CRC-32 / parity frame checker - testbench
// Streams frame beats at random pace while the result side stalls on its own
// pattern. A shadow of the parity and CRC-32 accumulators forecasts each
// frame result, which is compared field by field when it is taken.
// Directed frames cover the corners; random frames follow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BEATS  = 450;
    localparam int PHASES        = 12;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    crcpf_pkg::in_beat_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    crcpf_pkg::out_beat_t out_data;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [1:0]           cfg_wdata = 2'b00;

    // shadow accumulators and settings
    logic [31:0] acc_rem  = '0;
    logic        acc_par  = 1'b0;
    logic [1:0]  cur_mode = crcpf_pkg::MODE_EVEN;
    logic        cur_dir  = crcpf_pkg::DIR_GENERATE;
    logic [31:0] last_check = '0;
    crcpf_pkg::out_beat_t pending_checks[$];

    int beats_sent   = 0;
    int frames_done  = 0;
    int results_seen = 0;
    int errors_seen  = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit pacing       = 1'b1;
    int ready_mode   = 0;
    int ready_left   = 0;

    crc32_parity_frame_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result-side back-pressure: free-flowing, coin-toss or mostly stalled
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(8, 80);
        end
        ready_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic logic [31:0] crc_shift(input logic [31:0] rem, input logic b,
                                              input logic dir);
        logic [31:0] nxt;
        if (dir == crcpf_pkg::DIR_GENERATE)
        begin
            nxt = {rem[30:0], 1'b0} ^ ({32{rem[31] ^ b}} & crcpf_pkg::POLY_LOW);
        end
        else
        begin
            nxt = {rem[30:0], b} ^ ({32{rem[31]}} & crcpf_pkg::POLY_LOW);
        end
        return nxt;
    endfunction

    function automatic void predict_check_word(input crcpf_pkg::in_beat_t b);
        int unsigned          n;
        int unsigned          i;
        crcpf_pkg::out_beat_t res;
        n = 32'((b.bit_count > crcpf_pkg::MAX_BITS) ? crcpf_pkg::MAX_BITS : b.bit_count);
        for (i = 0; i < n; i++)
        begin
            acc_par = acc_par ^ b.data_bits[7 - i];
            acc_rem = crc_shift(acc_rem, b.data_bits[7 - i], cur_dir);
        end
        if (b.last)
        begin
            if (cur_mode[1])
            begin
                res.check_value = acc_rem;
                res.error       = (cur_dir == crcpf_pkg::DIR_VERIFY) && (acc_rem != '0);
            end
            else
            begin
                res.check_value = {31'd0, acc_par ^ cur_mode[0]};
                res.error       = (cur_dir == crcpf_pkg::DIR_VERIFY) ? res.check_value[0]
                                                                     : 1'b0;
            end
            pending_checks.push_back(res);
            last_check = res.check_value;
            frames_done++;
            acc_rem = '0;
            acc_par = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        crcpf_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.error)
            begin
                errors_seen++;
            end
            if (pending_checks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h err %b",
                                          out_data.check_value, out_data.error));
            end
            else
            begin
                want = pending_checks.pop_front();
                if (out_data.check_value !== want.check_value)
                begin
                    report_mismatch($sformatf("check_value got %h exp %h",
                                              out_data.check_value, want.check_value));
                end
                if (out_data.error !== want.error)
                begin
                    report_mismatch($sformatf("error got %b exp %b",
                                              out_data.error, want.error));
                end
            end
        end
    end

    task automatic set_config(input logic [1:0] mode, input logic dir);
        cfg_we    <= 1'b1;
        cfg_index <= crcpf_pkg::REG_CHECK_MODE;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_index <= crcpf_pkg::REG_DIRECTION;
        cfg_wdata <= {1'b0, dir};
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_mode = mode;
        cur_dir  = dir;
        @(negedge clk);
    endtask

    task automatic send_beat(input logic [7:0] d, input logic [3:0] n, input logic l);
        crcpf_pkg::in_beat_t b;
        b.data_bits = d;
        b.bit_count = n;
        b.last      = l;
        if (pacing && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        in_data  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_check_word(b);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_checks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // message beats, then the check bits (sometimes corrupted) when verifying
    task automatic send_frame(input int unsigned msg_len, input bit corrupt);
        logic [31:0] gen_rem;
        logic        par;
        logic [7:0]  d;
        logic [3:0]  n;
        int unsigned i;
        int unsigned k;
        gen_rem = '0;
        par     = 1'b0;
        for (i = 0; i < msg_len; i++)
        begin
            d = 8'($urandom_range(0, 255));
            n = 4'($urandom_range(1, 8));
            for (k = 0; k < n; k++)
            begin
                par     = par ^ d[7 - k];
                gen_rem = crc_shift(gen_rem, d[7 - k], crcpf_pkg::DIR_GENERATE);
            end
            send_beat(d, n, (cur_dir == crcpf_pkg::DIR_GENERATE) && (i == msg_len - 1));
        end
        if (cur_dir == crcpf_pkg::DIR_VERIFY)
        begin
            if (corrupt)
            begin
                gen_rem = gen_rem ^ (32'd1 << $urandom_range(0, 31));
                par     = ~par;
            end
            if (cur_mode[1])
            begin
                for (k = 0; k < 4; k++)
                begin
                    send_beat(gen_rem[31 - 8 * k -: 8], 4'($urandom_range(8, 15)), k == 3);
                end
            end
            else
            begin
                send_beat({par ^ cur_mode[0], 7'($urandom_range(0, 127))}, 4'd1, 1'b1);
            end
        end
    endtask

    task automatic send_noise(input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
        begin
            send_beat(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      (i == len - 1) || ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic test_parity_cases();
        set_config(crcpf_pkg::MODE_EVEN, crcpf_pkg::DIR_GENERATE);
        send_beat(8'hFF, 4'd8, 1'b1);
        send_beat(8'h80, 4'd1, 1'b1);
        send_beat(8'h00, 4'd0, 1'b1);
        drain();
        set_config(crcpf_pkg::MODE_ODD, crcpf_pkg::DIR_VERIFY);
        send_beat(8'hA5, 4'd8, 1'b0);
        send_beat(8'h01, 4'd8, 1'b1);
        send_beat(8'hFF, 4'd15, 1'b1);
        drain();
        set_config(crcpf_pkg::MODE_EVEN, crcpf_pkg::DIR_VERIFY);
        send_beat(8'h7F, 4'd9, 1'b1);
        send_beat(8'h00, 4'd8, 1'b1);
        drain();
    endtask

    task automatic test_crc_cases();
        logic [31:0] sig;
        int          k;
        set_config(crcpf_pkg::MODE_CRC, crcpf_pkg::DIR_GENERATE);
        for (k = 0; k < 4; k++)
        begin
            send_beat(8'h31 + 8'(k), 4'd8, k == 3);
        end
        drain();
        sig = last_check;
        // same message with its remainder appended must divide clean
        set_config(crcpf_pkg::MODE_CRC, crcpf_pkg::DIR_VERIFY);
        for (k = 0; k < 4; k++)
        begin
            send_beat(8'h31 + 8'(k), 4'd8, 1'b0);
        end
        for (k = 0; k < 4; k++)
        begin
            send_beat(sig[31 - 8 * k -: 8], 4'd8, k == 3);
        end
        drain();
        set_config(crcpf_pkg::MODE_CRC_ALT, crcpf_pkg::DIR_VERIFY);
        send_beat(8'h01, 4'd8, 1'b1);
        send_beat(8'hE0, 4'd3, 1'b0);
        send_beat(8'hFF, 4'd0, 1'b0);
        send_beat(8'hA8, 4'd5, 1'b1);
        drain();
        // direction flips part way through a frame
        send_beat(8'hC3, 4'd8, 1'b0);
        drain();
        set_config(crcpf_pkg::MODE_CRC_ALT, crcpf_pkg::DIR_GENERATE);
        send_beat(8'h3C, 4'd8, 1'b1);
        drain();
    endtask

    task automatic test_random_frames();
        int         ph;
        int         phase_start;
        logic [1:0] mode;
        logic       dir;
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 8)
            begin
                mode = 2'(ph % 4);
                dir  = 1'((ph / 4) % 2);
            end
            else
            begin
                mode = 2'($urandom_range(0, 3));
                dir  = 1'($urandom_range(0, 1));
            end
            set_config(mode, dir);
            pacing      = (ph % 3 != 2);
            phase_start = beats_sent;
            while (beats_sent - phase_start < RANDOM_BEATS / PHASES)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    send_frame($urandom_range(1, 6), $urandom_range(0, 3) == 0);
                end
                else
                begin
                    send_noise($urandom_range(1, 5));
                end
            end
            drain();
        end
        pacing = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_parity_cases();
        test_crc_cases();
        test_random_frames();
        $display("Sent %0d beats in %0d frames over all check modes and both directions",
                 beats_sent, frames_done);
        $display("Checked %0d results, %0d flagged as errors, %0d mismatches",
                 results_seen, errors_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/crcpf_pkg.sv
design/crcpf_in_stage.sv
design/crcpf_engine.sv
design/crcpf_out_stage.sv
design/crc32_parity_frame_checker_core.sv
tb/sv/testbench.sv
